// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sse_pkg.sv =====
// Types and constants for the sorted set engine.
package sse_pkg;

  localparam logic [2:0] CMD_INSERT      = 3'd0;
  localparam logic [2:0] CMD_SEARCH      = 3'd1;
  localparam logic [2:0] CMD_RM_FIRST    = 3'd2;
  localparam logic [2:0] CMD_RM_LAST     = 3'd3;
  localparam logic [2:0] CMD_RM_AT       = 3'd4;
  localparam logic [2:0] CMD_COUNT_BELOW = 3'd5;

  localparam logic [2:0] RS_DONE    = 3'd0;
  localparam logic [2:0] RS_EMPTY   = 3'd1;
  localparam logic [2:0] RS_FULL    = 3'd2;
  localparam logic [2:0] RS_DUP     = 3'd3;
  localparam logic [2:0] RS_BADPOS  = 3'd4;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [6:0] count_below;
    logic [6:0] set_size;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SRCH_END,
    ST_EQ,
    ST_SHIFT_UP,
    ST_INS_WR,
    ST_SHIFT_DN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       load_op;
    logic       srch_rd;
    logic       srch_cmp;
    logic       rd_lo;
    logic       up_init;
    logic       up_step;
    logic       ins_wr;
    logic       dn_init;
    logic       dn_sel_pos;
    logic       dn_step;
    logic       dec_count;
    logic       set_res;
    logic [2:0] res_status;
    logic       res_found;
    logic       res_below;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op_cmd;
    logic       count_zero;
    logic       full;
    logic       pos_bad;
    logic       lo_lt_hi;
    logic       lo_lt_count;
    logic       eq;
    logic       up_more;
    logic       dn_more;
    logic       pend;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/sse_dp.sv =====
// Datapath: entry store, counters, search bounds and result register.
module sse_dp import sse_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  req,
  input  logic      cfg_we,
  input  logic [6:0] cfg_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  logic signed [31:0] mem [STORE_DEPTH];
  logic signed [31:0] rd_data;
  logic [CW-1:0]      count;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      ptr;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic [2:0]         op_cmd;
  logic signed [31:0] op_val;
  logic [6:0]         op_pos;
  logic [6:0]         cap;
  logic [2:0]         res_status;
  logic               res_found;
  logic [6:0]         res_below;

  logic [CW:0]        bound_sum;
  logic [CW-1:0]      mid_next;
  logic [CW-1:0]      ptr_dec;
  logic [CW:0]        ptr_inc;
  logic [XW-1:0]      count_x;
  logic [XW-1:0]      cap_x;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      lo_x;
  logic               key_lt;
  logic               up_more;
  logic               dn_more;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  assign bound_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_next  = bound_sum[CW:1];
  assign ptr_dec   = ptr - CW'(1);
  assign ptr_inc   = {1'b0, ptr} + (CW+1)'(1);
  assign count_x   = XW'(count);
  assign cap_x     = XW'(cap);
  assign pos_x     = XW'(op_pos);
  assign lo_x      = XW'(lo);
  assign key_lt    = rd_data < op_val;
  assign up_more   = ptr > lo;
  assign dn_more   = ptr_inc < {1'b0, count};

  assign stat.op_cmd      = op_cmd;
  assign stat.count_zero  = (count == '0);
  assign stat.full        = (count_x >= cap_x) || (count_x >= XW'(STORE_DEPTH));
  assign stat.pos_bad     = (op_pos == '0) || (pos_x > count_x);
  assign stat.lo_lt_hi    = lo < hi;
  assign stat.lo_lt_count = lo < count;
  assign stat.eq          = (rd_data == op_val);
  assign stat.up_more     = up_more;
  assign stat.dn_more     = dn_more;
  assign stat.pend        = pend;
  assign stat.out_busy    = rsp_valid && !rsp_ready;

  always_comb begin
    wr_en   = ((cmd.up_step || cmd.dn_step) && pend) || cmd.ins_wr;
    wr_addr = cmd.ins_wr ? lo[AW-1:0] : pend_addr;
    wr_data = cmd.ins_wr ? op_val : rd_data;
    rd_en   = cmd.srch_rd || cmd.rd_lo || (cmd.up_step && up_more) ||
              (cmd.dn_step && dn_more);
    if (cmd.srch_rd) begin
      rd_addr = mid_next[AW-1:0];
    end else if (cmd.rd_lo) begin
      rd_addr = lo[AW-1:0];
    end else if (cmd.up_step) begin
      rd_addr = ptr_dec[AW-1:0];
    end else begin
      rd_addr = ptr_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // operands, bounds, pointers
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_cmd <= req.command;
      op_val <= req.value;
      op_pos <= req.position;
      lo     <= '0;
      hi     <= count;
    end
    if (cmd.srch_rd) begin
      mid <= mid_next;
    end
    if (cmd.srch_cmp) begin
      if (key_lt) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.up_init) begin
      ptr <= count;
    end else if (cmd.dn_init) begin
      ptr <= cmd.dn_sel_pos ? CW'(op_pos - 7'd1) : '0;
    end else if (cmd.up_step && up_more) begin
      pend_addr <= ptr[AW-1:0];
      ptr       <= ptr_dec;
    end else if (cmd.dn_step && dn_more) begin
      pend_addr <= ptr[AW-1:0];
      ptr       <= ptr_inc[CW-1:0];
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_found  <= cmd.res_found;
      res_below  <= cmd.res_below ? lo_x[6:0] : 7'd0;
    end
    if (cmd.emit) begin
      rsp.status      <= res_status;
      rsp.found       <= res_found;
      rsp.count_below <= res_below;
      rsp.set_size    <= count_x[6:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      cap       <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (cmd.ins_wr) begin
        count <= count + CW'(1);
      end else if (cmd.dec_count) begin
        count <= count - CW'(1);
      end
      if (cmd.up_init || cmd.dn_init) begin
        pend <= 1'b0;
      end else if (cmd.up_step) begin
        pend <= up_more;
      end else if (cmd.dn_step) begin
        pend <= dn_more;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/sse_ctrl.sv =====
// Controller: command sequencing state machine.
module sse_ctrl import sse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_op = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op_cmd)
          CMD_INSERT: begin
            if (stat.full) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = RS_FULL;
              state_next     = ST_FIN;
            end else begin
              state_next = ST_SRCH_RD;
            end
          end
          CMD_SEARCH: begin
            if (stat.count_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = RS_EMPTY;
              state_next     = ST_FIN;
            end else begin
              state_next = ST_SRCH_RD;
            end
          end
          CMD_RM_FIRST: begin
            if (stat.count_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = RS_EMPTY;
              state_next     = ST_FIN;
            end else begin
              cmd.dn_init = 1'b1;
              state_next  = ST_SHIFT_DN;
            end
          end
          CMD_RM_LAST: begin
            cmd.set_res = 1'b1;
            if (stat.count_zero) begin
              cmd.res_status = RS_EMPTY;
            end else begin
              cmd.res_status = RS_DONE;
              cmd.dec_count  = 1'b1;
            end
            state_next = ST_FIN;
          end
          CMD_RM_AT: begin
            if (stat.count_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = RS_EMPTY;
              state_next     = ST_FIN;
            end else if (stat.pos_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = RS_BADPOS;
              state_next     = ST_FIN;
            end else begin
              cmd.dn_init    = 1'b1;
              cmd.dn_sel_pos = 1'b1;
              state_next     = ST_SHIFT_DN;
            end
          end
          CMD_COUNT_BELOW: begin
            state_next = ST_SRCH_RD;
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = RS_DONE;
            state_next     = ST_FIN;
          end
        endcase
      end
      ST_SRCH_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_next  = ST_SRCH_CMP;
        end else begin
          state_next = ST_SRCH_END;
        end
      end
      ST_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = ST_SRCH_RD;
      end
      ST_SRCH_END: begin
        if (stat.op_cmd == CMD_COUNT_BELOW) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = RS_DONE;
          cmd.res_below  = 1'b1;
          state_next     = ST_FIN;
        end else if (stat.lo_lt_count) begin
          cmd.rd_lo  = 1'b1;
          state_next = ST_EQ;
        end else if (stat.op_cmd == CMD_SEARCH) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = RS_DONE;
          state_next     = ST_FIN;
        end else begin
          cmd.up_init = 1'b1;
          state_next  = ST_SHIFT_UP;
        end
      end
      ST_EQ: begin
        if (stat.op_cmd == CMD_SEARCH) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = RS_DONE;
          cmd.res_found  = stat.eq;
          state_next     = ST_FIN;
        end else if (stat.eq) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = RS_DUP;
          state_next     = ST_FIN;
        end else begin
          cmd.up_init = 1'b1;
          state_next  = ST_SHIFT_UP;
        end
      end
      ST_SHIFT_UP: begin
        cmd.up_step = 1'b1;
        if (!stat.up_more) begin
          state_next = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        cmd.ins_wr     = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = RS_DONE;
        state_next     = ST_FIN;
      end
      ST_SHIFT_DN: begin
        cmd.dn_step = 1'b1;
        if (!stat.dn_more) begin
          cmd.dec_count  = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = RS_DONE;
          state_next     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sorted_set_engine.sv =====
// Sorted set engine top level: controller plus datapath.
//
//   channel | dir | payload    | beat
//   req     | in  | in_item_t  | req_valid & req_ready
//   rsp     | out | out_item_t | rsp_valid & rsp_ready
//   cfg     | in  | 7-bit cap  | cfg_valid & cfg_ready
//
// One command at a time, from the accept cycle through the emit cycle. Search and count
// below run a binary search, each step a store read followed by a compare (one store
// read port); insert then shifts the entries from the slot upward up one place; remove
// first/at shift the later entries down one place; remove last and commands answered
// in decode finish without touching the store.
// Synchronous reset empties the set and sets the cap to 64; no clearing pass.
// A finished beat waits in the rsp register; the next req beat is taken meanwhile.
`include "assert_macros.svh"

module sorted_set_engine import sse_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  in_item_t   req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output out_item_t  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sse_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  `ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready, "req while busy")
  `ASSERT_IMPLIES(a_emit_slot_free, clk, rst, cmd.emit, !rsp_valid || rsp_ready, "rsp overwritten")
  `ASSERT_IMPLIES(a_ins_no_pend, clk, rst, cmd.ins_wr, !stat.pend, "insert with shift pending")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted set engine: directed and random commands, scoreboard.
import sse_pkg::*;

localparam int SET_DEPTH = 64;
localparam logic [2:0] CMD_SPARE6 = 3'd6;
localparam logic [2:0] CMD_SPARE7 = 3'd7;

typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

class set_scoreboard;
  logic signed [31:0] entries [SET_DEPTH];
  int unsigned count;
  int unsigned cap_limit;
  out_item_t   pending [$];
  int unsigned errors;
  int unsigned beats;

  function new();
    count = 0;
    cap_limit = 32'(CAP_RESET);
    errors = 0;
    beats = 0;
  endfunction

  function void set_cap(logic [6:0] c);
    cap_limit = 32'(c);
  endfunction

  function int unsigned num_below(logic signed [31:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < count; i++)
      if (entries[i] < v) n++;
    return n;
  endfunction

  function void close_gap(int unsigned idx);
    for (int unsigned i = idx; i + 1 < count; i++)
      entries[i] = entries[i + 1];
    count--;
  endfunction

  function void note_cmd(in_item_t it);
    out_item_t          e;
    logic signed [31:0] v;
    int unsigned        lim;
    int unsigned        idx;
    int unsigned        pos;
    v = it.value;
    pos = 32'(it.position);
    e = '0;
    e.status = RS_DONE;
    lim = (cap_limit > SET_DEPTH) ? SET_DEPTH : cap_limit;
    case (it.command)
      CMD_INSERT: begin
        if (count >= lim) begin
          e.status = RS_FULL;
        end else begin
          idx = num_below(v);
          if (idx < count && entries[idx] == v) begin
            e.status = RS_DUP;
          end else begin
            for (int i = count; i > idx; i--)
              entries[i] = entries[i - 1];
            entries[idx] = v;
            count++;
          end
        end
      end
      CMD_SEARCH: begin
        if (count == 0) begin
          e.status = RS_EMPTY;
        end else begin
          idx = num_below(v);
          e.found = (idx < count && entries[idx] == v);
        end
      end
      CMD_RM_FIRST: begin
        if (count == 0) e.status = RS_EMPTY;
        else close_gap(0);
      end
      CMD_RM_LAST: begin
        if (count == 0) e.status = RS_EMPTY;
        else count--;
      end
      CMD_RM_AT: begin
        if (count == 0) e.status = RS_EMPTY;
        else if (pos == 0 || pos > count) e.status = RS_BADPOS;
        else close_gap(pos - 1);
      end
      CMD_COUNT_BELOW: begin
        e.count_below = 7'(num_below(v));
      end
      default: ;
    endcase
    e.set_size = 7'(count);
    pending.push_back(e);
  endfunction

  task report(string msg);
    $display("mismatch at response beat %0d: %s", beats, msg);
    errors++;
  endtask

  task check_rsp(out_item_t got);
    out_item_t want;
    beats++;
    if (pending.size() == 0) begin
      report("response with nothing outstanding");
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.found !== want.found)
      report($sformatf("found %0d, expected %0d", got.found, want.found));
    if (got.count_below !== want.count_below)
      report($sformatf("count_below %0d, expected %0d", got.count_below, want.count_below));
    if (got.set_size !== want.set_size)
      report($sformatf("set_size %0d, expected %0d", got.set_size, want.set_size));
  endtask
endclass

module tb_top;
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  in_item_t   req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  out_item_t  rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  set_scoreboard sb = new();
  bit          idle_on = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned rsp_burst = 0;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE = 150;

  sorted_set_engine #(.STORE_DEPTH(SET_DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_rsp(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // response side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (rsp_burst > 0) begin
        rsp_ready <= 1'b0;
        rsp_burst--;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        rsp_burst = $urandom_range(1, 16) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 99) < 25) return $urandom_range(1, 16);
    return 0;
  endfunction

  function automatic in_item_t mk(logic [2:0] c, logic signed [31:0] v, logic [6:0] p);
    in_item_t it;
    it.command = c;
    it.value = v;
    it.position = p;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_value(int hit_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.count > 0 && r < hit_pct)
      return sb.entries[$urandom_range(0, sb.count - 1)];
    r = $urandom_range(0, 99);
    if (r < 35) return $signed($urandom_range(0, 200)) - 100;
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.count > 0 && r < 70) return 7'($urandom_range(1, sb.count));
    if (r < 80) return 7'd0;
    if (r < 90) return 7'($urandom_range(sb.count + 1, SET_DEPTH));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic in_item_t rand_cmd(mix_t mix);
    int       w [6];
    int       r;
    int       acc;
    in_item_t it;
    case (mix)
      MIX_FILL:     w = '{75, 6, 3, 3, 4, 6};
      MIX_BALANCED: w = '{35, 15, 8, 8, 14, 15};
      default:      w = '{15, 12, 18, 18, 25, 9};
    endcase
    it.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
    r = $urandom_range(0, 99);
    acc = 0;
    for (int i = 0; i < 6; i++) begin
      acc += w[i];
      if (r < acc) begin
        it.command = 3'(i);
        break;
      end
    end
    it.value = pick_value(it.command == CMD_INSERT ? 25 : 50);
    it.position = (it.command == CMD_RM_AT) ? pick_pos() : 7'($urandom_range(0, 127));
    return it;
  endfunction

  task automatic send_cmd(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    sb.note_cmd(it);
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_cap(input logic [6:0] c);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    sb.set_cap(c);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] c, input mix_t mix, input int n);
    write_cap(c);
    repeat (n) send_cmd(rand_cmd(mix));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty and small set corner cases and unused codes
    send_cmd(mk(CMD_RM_FIRST, 32'sd0, 7'd1));
    send_cmd(mk(CMD_RM_LAST, 32'sd0, 7'd1));
    send_cmd(mk(CMD_RM_AT, 32'sd0, 7'd1));
    send_cmd(mk(CMD_SEARCH, 32'sd0, 7'd0));
    send_cmd(mk(CMD_COUNT_BELOW, 32'sh7fff_ffff, 7'd0));
    send_cmd(mk(CMD_SPARE6, -32'sd1, 7'h7f));
    send_cmd(mk(CMD_SPARE7, 32'sd5, 7'd3));
    send_cmd(mk(CMD_INSERT, 32'sd0, 7'd0));
    send_cmd(mk(CMD_INSERT, 32'sh8000_0000, 7'd0));
    send_cmd(mk(CMD_INSERT, 32'sh7fff_ffff, 7'd0));
    send_cmd(mk(CMD_INSERT, -32'sd1, 7'd0));
    send_cmd(mk(CMD_INSERT, 32'sd0, 7'd0));
    send_cmd(mk(CMD_SEARCH, 32'sd0, 7'd0));
    send_cmd(mk(CMD_SEARCH, 32'sd5, 7'd0));
    send_cmd(mk(CMD_COUNT_BELOW, 32'sh7fff_ffff, 7'd0));
    send_cmd(mk(CMD_COUNT_BELOW, 32'sh8000_0000, 7'd0));
    send_cmd(mk(CMD_RM_AT, 32'sd0, 7'd0));
    send_cmd(mk(CMD_RM_AT, 32'sd0, 7'd5));
    send_cmd(mk(CMD_RM_AT, 32'sd0, 7'd64));
    send_cmd(mk(CMD_RM_AT, 32'sd0, 7'd2));
    send_cmd(mk(CMD_RM_FIRST, 32'sd0, 7'd0));
    send_cmd(mk(CMD_RM_LAST, 32'sd0, 7'd0));
    send_cmd(mk(CMD_COUNT_BELOW, 32'sd0, 7'd0));
    // limit lowered below the count, then zero limit on an empty set
    write_cap(7'd0);
    send_cmd(mk(CMD_INSERT, 32'sd9, 7'd0));
    send_cmd(mk(CMD_RM_LAST, 32'sd0, 7'd0));
    send_cmd(mk(CMD_INSERT, 32'sd9, 7'd0));

    // back-pressure: response side holds off while requests keep coming
    write_cap(7'd64);
    idle_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (8) send_cmd(rand_cmd(MIX_FILL));
    drain();
    idle_on = 1'b1;

    run_phase(7'd64, MIX_FILL, 250);
    run_phase(7'd127, MIX_BALANCED, 150);
    run_phase(7'd10, MIX_BALANCED, 100);
    run_phase(7'd0, MIX_BALANCED, 50);
    run_phase(7'd1, MIX_FILL, 60);
    run_phase(7'd100, MIX_FILL, 200);
    run_phase(7'd64, MIX_DRAIN, 200);
    run_phase(7'd33, MIX_BALANCED, 150);
    write_cap(7'd64);
    idle_on = 1'b0;
    repeat (240) send_cmd(rand_cmd(MIX_BALANCED));

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/sse_pkg.sv
rtl/sse_dp.sv
rtl/sse_ctrl.sv
rtl/sorted_set_engine.sv
tb/tb_top.sv
